// ===== sv/mmcs_pkg.sv =====
// Shared types, codes and sequence ROM for the mount move command sequencer.
// No dependencies.
package mmcs_pkg;

  localparam int MAX_SEQ_DEFAULT = 8;
  localparam int ROM_DEPTH       = 8;
  localparam int ROM_IDX_W       = 3;
  localparam int ROM_LEN_W       = 4;
  localparam int CODE_W          = 5;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_AXES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_DEC  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_RA   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCUS_FAST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCUS_MEDIUM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW_MODE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IFACE_SEL    = 3'd6;

  typedef enum logic [1:0] {
    IF_MANUAL = 2'd0,
    IF_PADDLE = 2'd1,
    IF_ASCII  = 2'd2,
    IF_RSVD   = 2'd3
  } iface_e;

  // direction and final codes
  localparam logic [CODE_W-1:0] CODE_STOP       = 5'd0;
  localparam logic [CODE_W-1:0] CODE_LEFT       = 5'd1;
  localparam logic [CODE_W-1:0] CODE_RIGHT      = 5'd2;
  localparam logic [CODE_W-1:0] CODE_UP         = 5'd3;
  localparam logic [CODE_W-1:0] CODE_DOWN       = 5'd4;
  localparam logic [CODE_W-1:0] CODE_SLEW_STOP  = 5'd5;
  localparam logic [CODE_W-1:0] CODE_SLEW_LEFT  = 5'd6;
  localparam logic [CODE_W-1:0] CODE_SLEW_RIGHT = 5'd7;
  localparam logic [CODE_W-1:0] CODE_SLEW_UP    = 5'd8;
  localparam logic [CODE_W-1:0] CODE_SLEW_DOWN  = 5'd9;
  localparam logic [CODE_W-1:0] CODE_FOCUS_STOP = 5'd10;
  localparam logic [CODE_W-1:0] CODE_FOCUS_IN   = 5'd11;
  localparam logic [CODE_W-1:0] CODE_FOCUS_OUT  = 5'd12;
  localparam logic [CODE_W-1:0] CODE_FIN_MED    = 5'd13;
  localparam logic [CODE_W-1:0] CODE_FOUT_MED   = 5'd14;
  localparam logic [CODE_W-1:0] CODE_FIN_FAST   = 5'd15;
  localparam logic [CODE_W-1:0] CODE_FOUT_FAST  = 5'd16;
  localparam logic [CODE_W-1:0] SLEW_OFFSET     = 5'd5;
  localparam logic [CODE_W-1:0] FOCUS_MED_OFS   = 5'd2;
  localparam logic [CODE_W-1:0] FOCUS_FAST_OFS  = 5'd4;

  // entry: bit 8 set marks a drain-and-wait, low byte is byte or delay
  typedef logic [8:0] entry_t;

  typedef struct packed {
    logic [ROM_LEN_W-1:0]     len;
    entry_t [ROM_DEPTH-1:0]   e;
  } seq_t;

  typedef struct packed {
    logic load;
    logic emit;
    logic last;
  } mmcs_cmd_t;

  function automatic entry_t by(input logic [7:0] c);
    return {1'b0, c};
  endfunction

  function automatic entry_t dly(input logic [7:0] d);
    return {1'b1, d};
  endfunction

  function automatic seq_t mk(input logic [ROM_LEN_W-1:0] len,
                              input entry_t e0, input entry_t e1,
                              input entry_t e2, input entry_t e3,
                              input entry_t e4, input entry_t e5,
                              input entry_t e6, input entry_t e7);
    seq_t s;
    s.len  = len;
    s.e[0] = e0;
    s.e[1] = e1;
    s.e[2] = e2;
    s.e[3] = e3;
    s.e[4] = e4;
    s.e[5] = e5;
    s.e[6] = e6;
    s.e[7] = e7;
    return s;
  endfunction

  function automatic seq_t paddle_seq(input logic [CODE_W-1:0] code);
    entry_t z;
    seq_t   s;
    z = by(8'h00);
    unique case (code)
      CODE_STOP, CODE_SLEW_STOP: s = mk(4'd1, z, z, z, z, z, z, z, z);
      CODE_LEFT:  s = mk(4'd2, by(8'h08), by(8'h18), z, z, z, z, z, z);
      CODE_RIGHT: s = mk(4'd2, by(8'h01), by(8'h11), z, z, z, z, z, z);
      CODE_UP:    s = mk(4'd2, by(8'h04), by(8'h14), z, z, z, z, z, z);
      CODE_DOWN:  s = mk(4'd2, by(8'h02), by(8'h12), z, z, z, z, z, z);
      CODE_SLEW_LEFT:
        s = mk(4'd4, by(8'h08), by(8'h18), dly(8'd100), by(8'h19), z, z, z, z);
      CODE_SLEW_RIGHT:
        s = mk(4'd4, by(8'h01), by(8'h11), dly(8'd100), by(8'h19), z, z, z, z);
      CODE_SLEW_UP:
        s = mk(4'd4, by(8'h04), by(8'h14), dly(8'd100), by(8'h16), z, z, z, z);
      CODE_SLEW_DOWN:
        s = mk(4'd4, by(8'h02), by(8'h12), dly(8'd100), by(8'h16), z, z, z, z);
      default:    s = mk(4'd0, z, z, z, z, z, z, z, z);
    endcase
    return s;
  endfunction

  function automatic seq_t ascii_seq(input logic [CODE_W-1:0] code);
    entry_t z;
    entry_t c;
    entry_t h;
    seq_t   s;
    z = by(8'h00);
    c = by(":");
    h = by("#");
    unique case (code)
      CODE_STOP:       s = mk(4'd3, c, by("Q"), h, z, z, z, z, z);
      CODE_LEFT:       s = mk(4'd4, c, by("M"), by("e"), h, z, z, z, z);
      CODE_RIGHT:      s = mk(4'd4, c, by("M"), by("w"), h, z, z, z, z);
      CODE_UP:         s = mk(4'd4, c, by("M"), by("n"), h, z, z, z, z);
      CODE_DOWN:       s = mk(4'd4, c, by("M"), by("s"), h, z, z, z, z);
      CODE_SLEW_STOP:  s = mk(4'd7, c, by("Q"), h, c, by("R"), by("G"), h, z);
      CODE_SLEW_LEFT:  s = mk(4'd8, c, by("R"), by("C"), h, c, by("M"), by("e"), h);
      CODE_SLEW_RIGHT: s = mk(4'd8, c, by("R"), by("C"), h, c, by("M"), by("w"), h);
      CODE_SLEW_UP:    s = mk(4'd8, c, by("R"), by("C"), h, c, by("M"), by("n"), h);
      CODE_SLEW_DOWN:  s = mk(4'd8, c, by("R"), by("C"), h, c, by("M"), by("s"), h);
      CODE_FOCUS_STOP: s = mk(4'd4, c, by("F"), by("Q"), h, z, z, z, z);
      CODE_FOCUS_IN:   s = mk(4'd8, c, by("F"), by("S"), h, c, by("F"), by("+"), h);
      CODE_FOCUS_OUT:  s = mk(4'd8, c, by("F"), by("S"), h, c, by("F"), by("-"), h);
      CODE_FIN_MED:    s = mk(4'd8, c, by("F"), by("M"), h, c, by("F"), by("+"), h);
      CODE_FOUT_MED:   s = mk(4'd8, c, by("F"), by("M"), h, c, by("F"), by("-"), h);
      CODE_FIN_FAST:   s = mk(4'd8, c, by("F"), by("F"), h, c, by("F"), by("+"), h);
      CODE_FOUT_FAST:  s = mk(4'd8, c, by("F"), by("F"), h, c, by("F"), by("-"), h);
      default:         s = mk(4'd3, c, by("Q"), h, z, z, z, z, z);
    endcase
    return s;
  endfunction

endpackage

// ===== sv/mmcs_ctrl.sv =====
// Sequencer controller: accepts a request and steps through its entries.
// Depends on mmcs_pkg.
module mmcs_ctrl #(
  parameter int MAX_SEQUENCE = mmcs_pkg::MAX_SEQ_DEFAULT,
  parameter int IdxW         = $clog2(MAX_SEQUENCE),
  parameter int LenW         = $clog2(MAX_SEQUENCE + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [LenW-1:0]      seq_len_i,
  output logic                 busy_o,
  output mmcs_pkg::mmcs_cmd_t  cmd_o,
  output logic [IdxW-1:0]      idx_o
);
  import mmcs_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e          state_q;
  logic [IdxW-1:0] idx_q;
  logic            empty;
  logic            last;

  assign empty = (seq_len_i == '0);
  assign last  = ({{(LenW-IdxW){1'b0}}, idx_q} == seq_len_i - LenW'(1));

  always_comb begin
    cmd_o.load = start_i && (state_q == ST_IDLE);
    cmd_o.emit = (state_q == ST_EMIT) && !empty;
    cmd_o.last = last;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign idx_o  = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_EMIT;
            idx_q   <= '0;
          end
        end
        ST_EMIT: begin
          if (empty || last) begin
            state_q <= ST_IDLE;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/mmcs_dp.sv =====
// Sequencer datapath: config registers, direction remap, sequence lookup
// and the result register. Depends on mmcs_pkg.
module mmcs_dp #(
  parameter int MAX_SEQUENCE = mmcs_pkg::MAX_SEQ_DEFAULT,
  parameter int IdxW         = $clog2(MAX_SEQUENCE),
  parameter int LenW         = $clog2(MAX_SEQUENCE + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mmcs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mmcs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic [mmcs_pkg::CODE_W-1:0]       direction_i,
  input  mmcs_pkg::mmcs_cmd_t               cmd_i,
  input  logic [IdxW-1:0]                   idx_i,
  output logic [LenW-1:0]                   seq_len_o,
  output logic                              result_strobe_o,
  output logic                              entry_kind_o,
  output logic [7:0]                        out_byte_o,
  output logic [7:0]                        delay_ms_o,
  output logic                              last_entry_o
);
  import mmcs_pkg::*;

  logic        swap_axes_q, reverse_dec_q, reverse_ra_q;
  logic        focus_fast_q, focus_medium_q, slew_mode_q;
  iface_e      iface_q;

  logic [CODE_W-1:0] swapped;
  logic [CODE_W-1:0] mapped;
  logic [CODE_W-1:0] code;
  seq_t              seq_d, seq_q;
  logic [LenW-1:0]   rom_len;
  entry_t            entry;

  logic       strobe_q, kind_q, last_q;
  logic [7:0] byte_q, delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_axes_q    <= 1'b0;
      reverse_dec_q  <= 1'b0;
      reverse_ra_q   <= 1'b0;
      focus_fast_q   <= 1'b0;
      focus_medium_q <= 1'b0;
      slew_mode_q    <= 1'b0;
      iface_q        <= IF_MANUAL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SWAP_AXES:    swap_axes_q    <= cfg_wdata_i[0];
        CFG_REVERSE_DEC:  reverse_dec_q  <= cfg_wdata_i[0];
        CFG_REVERSE_RA:   reverse_ra_q   <= cfg_wdata_i[0];
        CFG_FOCUS_FAST:   focus_fast_q   <= cfg_wdata_i[0];
        CFG_FOCUS_MEDIUM: focus_medium_q <= cfg_wdata_i[0];
        CFG_SLEW_MODE:    slew_mode_q    <= cfg_wdata_i[0];
        CFG_IFACE_SEL:    iface_q        <= iface_e'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // axis swap, then reversal, focus speed, catch-all to stop, slew offset
  always_comb begin
    swapped = direction_i;
    if (swap_axes_q) begin
      case (direction_i)
        CODE_UP:    swapped = CODE_RIGHT;
        CODE_DOWN:  swapped = CODE_LEFT;
        CODE_LEFT:  swapped = CODE_UP;
        CODE_RIGHT: swapped = CODE_DOWN;
        default:    swapped = direction_i;
      endcase
    end
    case (swapped)
      CODE_UP:    mapped = reverse_dec_q ? CODE_DOWN : CODE_UP;
      CODE_DOWN:  mapped = reverse_dec_q ? CODE_UP : CODE_DOWN;
      CODE_LEFT:  mapped = reverse_ra_q ? CODE_RIGHT : CODE_LEFT;
      CODE_RIGHT: mapped = reverse_ra_q ? CODE_LEFT : CODE_RIGHT;
      CODE_FOCUS_IN, CODE_FOCUS_OUT: begin
        if (focus_fast_q) begin
          mapped = swapped + FOCUS_FAST_OFS;
        end else if (focus_medium_q) begin
          mapped = swapped + FOCUS_MED_OFS;
        end else begin
          mapped = swapped;
        end
      end
      CODE_FOCUS_STOP: mapped = CODE_FOCUS_STOP;
      default:         mapped = CODE_STOP;
    endcase
    code = (slew_mode_q && (mapped <= CODE_DOWN)) ? mapped + SLEW_OFFSET : mapped;
  end

  always_comb begin
    unique case (iface_q)
      IF_PADDLE: seq_d = paddle_seq(code);
      IF_ASCII:  seq_d = ascii_seq(code);
      default:   seq_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
    end else if (cmd_i.load) begin
      seq_q <= seq_d;
    end
  end

  assign rom_len   = LenW'(seq_q.len);
  assign seq_len_o = (rom_len > LenW'(MAX_SEQUENCE)) ? LenW'(MAX_SEQUENCE) : rom_len;
  assign entry     = seq_q.e[idx_i[ROM_IDX_W-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q  <= entry[8];
      byte_q  <= entry[8] ? 8'h00 : entry[7:0];
      delay_q <= entry[8] ? entry[7:0] : 8'h00;
      last_q  <= cmd_i.last;
    end
  end

  assign result_strobe_o = strobe_q;
  assign entry_kind_o    = kind_q;
  assign out_byte_o      = byte_q;
  assign delay_ms_o      = delay_q;
  assign last_entry_o    = last_q;

endmodule

// ===== sv/mount_move_command_sequencer.sv =====
// Top level of the mount move command sequencer.
// Instantiates mmcs_ctrl and mmcs_dp; depends on mmcs_pkg.
//
// A request is taken when start_i is high and busy_o is low. The direction
// is remapped by the config registers and its entry list latched at the
// accepting edge; busy_o then stays high while the entries leave one per
// cycle, each shown for a single cycle on result_strobe_o in the cycle
// after the controller's step. A sequence holds up to 8 entries; manual
// mode and empty sequences raise busy_o but emit nothing. The receiver
// cannot stall: every strobed beat must be taken when it appears.
module mount_move_command_sequencer #(
  parameter int MAX_SEQUENCE = mmcs_pkg::MAX_SEQ_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mmcs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mmcs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [mmcs_pkg::CODE_W-1:0]       direction_i,
  output logic                              result_strobe_o,
  output logic                              entry_kind_o,
  output logic [7:0]                        out_byte_o,
  output logic [7:0]                        delay_ms_o,
  output logic                              last_entry_o
);
  import mmcs_pkg::*;

  localparam int IdxW = $clog2(MAX_SEQUENCE);
  localparam int LenW = $clog2(MAX_SEQUENCE + 1);

  mmcs_cmd_t       cmd;
  logic [IdxW-1:0] idx;
  logic [LenW-1:0] seq_len;

  mmcs_ctrl #(
    .MAX_SEQUENCE (MAX_SEQUENCE),
    .IdxW         (IdxW),
    .LenW         (LenW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .seq_len_i (seq_len),
    .busy_o    (busy_o),
    .cmd_o     (cmd),
    .idx_o     (idx)
  );

  mmcs_dp #(
    .MAX_SEQUENCE (MAX_SEQUENCE),
    .IdxW         (IdxW),
    .LenW         (LenW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .direction_i     (direction_i),
    .cmd_i           (cmd),
    .idx_i           (idx),
    .seq_len_o       (seq_len),
    .result_strobe_o (result_strobe_o),
    .entry_kind_o    (entry_kind_o),
    .out_byte_o      (out_byte_o),
    .delay_ms_o      (delay_ms_o),
    .last_entry_o    (last_entry_o)
  );

endmodule

// ===== sv/mmcs_checker.sv =====
// Port-level checks for the mount move command sequencer, bound to the top.
// Depends on mmcs_pkg and mount_move_command_sequencer.
module mmcs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic                              result_strobe_o,
  input logic                              entry_kind_o,
  input logic [7:0]                        out_byte_o,
  input logic [7:0]                        delay_ms_o,
  input logic                              last_entry_o
);
  import mmcs_pkg::*;

  // an accepted request holds busy for at least the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy low right after accept");

  // every beat is produced by a step taken while busy
  a_beat_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(busy_o))
    else $error("beat without a running request");

  // beats of one sequence come back to back until the last one
  a_beats_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !last_entry_o) |=> result_strobe_o)
    else $error("gap inside a sequence");

  // a delay beat carries no byte, a byte beat no delay
  a_kind_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> (entry_kind_o ? (out_byte_o == 8'h00) : (delay_ms_o == 8'h00)))
    else $error("beat fields disagree with kind");

endmodule

bind mount_move_command_sequencer mmcs_checker u_mmcs_checker (.*);

// ===== tb/sv/tb.sv =====
// Testbench for mount_move_command_sequencer: directed and random direction requests under
// varied remap and interface settings, each beat checked against an in-bench sequence predictor.
// Depends on mmcs_pkg and the sequencer RTL.
module tb;
  import mmcs_pkg::*;

  localparam int                   HANG_LIMIT     = 2000;
  localparam int                   DRAIN_CYCLES   = 12;
  localparam int                   PHASE_ITEMS    = 22;
  localparam int                   RANDOM_PHASES  = 9;
  localparam logic [7:0]           SLEW_SETTLE_MS = 8'd100;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic [7:0] delay_ms;
    logic       last;
  } beat_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  start_i;
  logic                  busy_o;
  logic [CODE_W-1:0]     direction_i;
  logic                  result_strobe_o;
  logic                  entry_kind_o;
  logic [7:0]            out_byte_o;
  logic [7:0]            delay_ms_o;
  logic                  last_entry_o;

  // mirrored register state
  logic   cfg_swap;
  logic   cfg_rev_dec;
  logic   cfg_rev_ra;
  logic   cfg_focus_fast;
  logic   cfg_focus_med;
  logic   cfg_slew;
  iface_e cfg_iface;

  beat_t pending_beats[$];
  int    err_cnt = 0;
  int    stall_cycles = 0;
  bit    idle_on;

  mount_move_command_sequencer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .direction_i    (direction_i),
    .result_strobe_o(result_strobe_o),
    .entry_kind_o   (entry_kind_o),
    .out_byte_o     (out_byte_o),
    .delay_ms_o     (delay_ms_o),
    .last_entry_o   (last_entry_o)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [CODE_W-1:0] final_code(input logic [CODE_W-1:0] dir);
    logic [CODE_W-1:0] c;
    c = dir;
    if (cfg_swap) begin
      case (c)
        CODE_UP:    c = CODE_RIGHT;
        CODE_DOWN:  c = CODE_LEFT;
        CODE_LEFT:  c = CODE_UP;
        CODE_RIGHT: c = CODE_DOWN;
        default: ;
      endcase
    end
    case (c)
      CODE_UP:    if (cfg_rev_dec) c = CODE_DOWN;
      CODE_DOWN:  if (cfg_rev_dec) c = CODE_UP;
      CODE_LEFT:  if (cfg_rev_ra) c = CODE_RIGHT;
      CODE_RIGHT: if (cfg_rev_ra) c = CODE_LEFT;
      CODE_FOCUS_IN, CODE_FOCUS_OUT: begin
        if (cfg_focus_fast) c = c + FOCUS_FAST_OFS;
        else if (cfg_focus_med) c = c + FOCUS_MED_OFS;
      end
      CODE_FOCUS_STOP: ;
      default:    c = CODE_STOP;
    endcase
    if (c <= CODE_DOWN && cfg_slew) c = c + SLEW_OFFSET;
    return c;
  endfunction

  function automatic beat_t byte_entry(input logic [7:0] b);
    beat_t e;
    e = '0;
    e.out_byte = b;
    return e;
  endfunction

  function automatic void predict_sequence(input logic [CODE_W-1:0] dir);
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] mv;
    logic [7:0]        b0;
    logic [7:0]        b1;
    logic [7:0]        b_end;
    string             txt;
    beat_t             dly;
    beat_t             seq_q[$];
    code = final_code(dir);
    mv = (code >= CODE_SLEW_LEFT && code <= CODE_SLEW_DOWN) ? code - SLEW_OFFSET : code;
    case (mv)
      CODE_LEFT:  begin b0 = 8'h08; b1 = 8'h18; b_end = 8'h19; txt = "e"; end
      CODE_RIGHT: begin b0 = 8'h01; b1 = 8'h11; b_end = 8'h19; txt = "w"; end
      CODE_UP:    begin b0 = 8'h04; b1 = 8'h14; b_end = 8'h16; txt = "n"; end
      CODE_DOWN:  begin b0 = 8'h02; b1 = 8'h12; b_end = 8'h16; txt = "s"; end
      default:    begin b0 = 8'h00; b1 = 8'h00; b_end = 8'h00; txt = ""; end
    endcase
    if (cfg_iface == IF_PADDLE) begin
      if (code == CODE_STOP || code == CODE_SLEW_STOP) begin
        seq_q.push_back(byte_entry(8'h00));
      end else if (mv >= CODE_LEFT && mv <= CODE_DOWN) begin
        seq_q.push_back(byte_entry(b0));
        seq_q.push_back(byte_entry(b1));
        if (code >= CODE_SLEW_LEFT) begin
          dly = '0;
          dly.kind = 1'b1;
          dly.delay_ms = SLEW_SETTLE_MS;
          seq_q.push_back(dly);
          seq_q.push_back(byte_entry(b_end));
        end
      end
    end else if (cfg_iface == IF_ASCII) begin
      case (code)
        CODE_STOP:       txt = ":Q#";
        CODE_SLEW_STOP:  txt = ":Q#:RG#";
        CODE_LEFT, CODE_RIGHT, CODE_UP, CODE_DOWN: txt = {":M", txt, "#"};
        CODE_SLEW_LEFT, CODE_SLEW_RIGHT, CODE_SLEW_UP, CODE_SLEW_DOWN:
          txt = {":RC#:M", txt, "#"};
        CODE_FOCUS_STOP: txt = ":FQ#";
        CODE_FOCUS_IN:   txt = ":FS#:F+#";
        CODE_FOCUS_OUT:  txt = ":FS#:F-#";
        CODE_FIN_MED:    txt = ":FM#:F+#";
        CODE_FOUT_MED:   txt = ":FM#:F-#";
        CODE_FIN_FAST:   txt = ":FF#:F+#";
        CODE_FOUT_FAST:  txt = ":FF#:F-#";
        default:         txt = ":Q#";
      endcase
      for (int i = 0; i < txt.len(); i++) seq_q.push_back(byte_entry(txt[i]));
    end
    if (seq_q.size() > 0) seq_q[seq_q.size()-1].last = 1'b1;
    foreach (seq_q[i]) pending_beats.push_back(seq_q[i]);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && result_strobe_o === 1'b1) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat kind=%h byte=%h delay=%h last=%h", $time,
                 entry_kind_o, out_byte_o, delay_ms_o, last_entry_o);
        err_cnt++;
      end else begin
        want = pending_beats.pop_front();
        if (entry_kind_o !== want.kind) begin
          $display("%0t: entry_kind expected %h actual %h", $time, want.kind, entry_kind_o);
          err_cnt++;
        end
        if (out_byte_o !== want.out_byte) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, out_byte_o);
          err_cnt++;
        end
        if (delay_ms_o !== want.delay_ms) begin
          $display("%0t: delay_ms expected %h actual %h", $time, want.delay_ms, delay_ms_o);
          err_cnt++;
        end
        if (last_entry_o !== want.last) begin
          $display("%0t: last_entry expected %h actual %h", $time, want.last, last_entry_o);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any beat, accept or config write
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_strobe_o === 1'b1 || cfg_we_i) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= HANG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [CODE_W-1:0] dir);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i     <= 1'b1;
    direction_i <= dir;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_sequence(dir);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_beats.size() != 0 || busy_o) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_SWAP_AXES:    cfg_swap       = data[0];
      CFG_REVERSE_DEC:  cfg_rev_dec    = data[0];
      CFG_REVERSE_RA:   cfg_rev_ra     = data[0];
      CFG_FOCUS_FAST:   cfg_focus_fast = data[0];
      CFG_FOCUS_MEDIUM: cfg_focus_med  = data[0];
      CFG_SLEW_MODE:    cfg_slew       = data[0];
      CFG_IFACE_SEL:    cfg_iface      = iface_e'(data);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_manual_and_unused_index();
    send_item(5'd31);
    wait_idle();
    program_reg(CFG_IDX_UNUSED, 2'd3);
    send_item(CODE_STOP);
  endtask

  task automatic test_paddle_moves();
    wait_idle();
    program_reg(CFG_IFACE_SEL, IF_PADDLE);
    send_item(CODE_STOP);
    send_item(CODE_LEFT);
    send_item(CODE_RIGHT);
    send_item(CODE_UP);
    send_item(CODE_DOWN);
    send_item(CODE_FOCUS_IN);
  endtask

  task automatic test_paddle_slew();
    wait_idle();
    program_reg(CFG_SLEW_MODE, 2'd1);
    send_item(CODE_STOP);
    send_item(CODE_LEFT);
    send_item(CODE_RIGHT);
    send_item(CODE_UP);
    send_item(CODE_DOWN);
    send_item(5'd7);
  endtask

  task automatic test_ascii_focus_and_remap();
    wait_idle();
    program_reg(CFG_SLEW_MODE, 2'd0);
    program_reg(CFG_IFACE_SEL, IF_ASCII);
    program_reg(CFG_FOCUS_FAST, 2'd1);
    program_reg(CFG_FOCUS_MEDIUM, 2'd1);
    send_item(CODE_FOCUS_STOP);
    send_item(CODE_FOCUS_IN);
    send_item(CODE_FOCUS_OUT);
    wait_idle();
    program_reg(CFG_FOCUS_FAST, 2'd0);
    program_reg(CFG_SWAP_AXES, 2'd1);
    program_reg(CFG_REVERSE_DEC, 2'd1);
    program_reg(CFG_REVERSE_RA, 2'd1);
    send_item(CODE_FOCUS_IN);
    send_item(CODE_LEFT);
    send_item(CODE_RIGHT);
    send_item(CODE_UP);
    send_item(CODE_DOWN);
  endtask

  task automatic test_reserved_interface();
    wait_idle();
    program_reg(CFG_IFACE_SEL, IF_RSVD);
    send_item(CODE_LEFT);
  endtask

  task automatic test_random_traffic();
    logic [CODE_W-1:0] valid_dirs[8];
    int                sel;
    valid_dirs = '{CODE_STOP, CODE_LEFT, CODE_RIGHT, CODE_UP, CODE_DOWN,
                   CODE_FOCUS_STOP, CODE_FOCUS_IN, CODE_FOCUS_OUT};
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      idle_on = (ph != RANDOM_PHASES - 1);
      for (int r = CFG_SWAP_AXES; r <= CFG_SLEW_MODE; r++) begin
        if (ph == 0) program_reg(CFG_IDX_W'(r), 2'd3);
        else if (ph == 1) program_reg(CFG_IDX_W'(r), 2'd0);
        else program_reg(CFG_IDX_W'(r), CFG_DATA_W'($urandom_range(0, 3)));
      end
      sel = $urandom_range(0, 9);
      if (ph == 0) program_reg(CFG_IFACE_SEL, IF_ASCII);
      else if (ph == 1) program_reg(CFG_IFACE_SEL, IF_PADDLE);
      else if (sel < 4) program_reg(CFG_IFACE_SEL, IF_PADDLE);
      else if (sel < 8) program_reg(CFG_IFACE_SEL, IF_ASCII);
      else if (sel == 8) program_reg(CFG_IFACE_SEL, IF_MANUAL);
      else program_reg(CFG_IFACE_SEL, IF_RSVD);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 4) != 0) send_item(valid_dirs[$urandom_range(0, 7)]);
        else send_item(CODE_W'($urandom_range(0, 31)));
      end
    end
  endtask

  initial begin
    idle_on        = 1'b1;
    cfg_swap       = 1'b0;
    cfg_rev_dec    = 1'b0;
    cfg_rev_ra     = 1'b0;
    cfg_focus_fast = 1'b0;
    cfg_focus_med  = 1'b0;
    cfg_slew       = 1'b0;
    cfg_iface      = IF_MANUAL;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    start_i        = 1'b0;
    direction_i    = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_manual_and_unused_index();
    test_paddle_moves();
    test_paddle_slew();
    test_ascii_focus_and_remap();
    test_reserved_interface();
    test_random_traffic();

    wait_idle();
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
